// ===== rtl/core/byte_ring_buffer_defines.svh =====
// Assertion macros for the byte ring buffer checker.
`ifndef BYTE_RING_BUFFER_DEFINES_SVH
`define BYTE_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BRB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("brb check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BRB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("brb check failed");

`endif

// ===== rtl/core/brb_pkg.sv =====
// Package: field widths, operation codes and control structs of the byte ring buffer.
`timescale 1ns / 1ps
`default_nettype none
package brb_pkg;

	localparam int FUNC_W = 3;
	localparam int BYTE_W = 8;
	localparam int OFS_W  = 10;
	localparam int CNT_W  = 11;
	// head plus an addend before wrapping
	localparam int SUM_W  = 12;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

	localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch the incoming word
		logic exec;     // run the operation, touch the store
		logic load;     // fill the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free; // output register can take a word this cycle
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/brb_if.sv =====
// Channel interfaces: operation words in, result words out.
`timescale 1ns / 1ps
`default_nettype none
interface brb_in_if;
	logic                        valid;
	logic                        ready;
	logic [brb_pkg::FUNC_W-1:0]  func;
	logic [brb_pkg::BYTE_W-1:0]  data_in;
	logic [brb_pkg::OFS_W-1:0]   offset;
	logic [brb_pkg::CNT_W-1:0]   count;

	modport source (output valid, func, data_in, offset, count, input ready);
	modport sink   (input valid, func, data_in, offset, count, output ready);
endinterface

interface brb_out_if;
	logic                        valid;
	logic                        ready;
	logic [brb_pkg::BYTE_W-1:0]  data_out;
	logic                        done_res;
	logic [brb_pkg::CNT_W-1:0]   moved;
	logic [brb_pkg::CNT_W-1:0]   fill_level;
	logic [brb_pkg::CNT_W-1:0]   free_space;

	modport source (output valid, data_out, done_res, moved, fill_level, free_space,
		input ready);
	modport sink   (input valid, data_out, done_res, moved, fill_level, free_space,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/brb_ram.sv =====
// Generic single-clock RAM, one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]          wdata,
	input  wire logic                      re,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr,
	output logic      [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/brb_ctrl.sv =====
// Controller: sequences accept, execute and result load for one word at a time.
`timescale 1ns / 1ps
`default_nettype none
module brb_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire brb_pkg::stat_t stat,
	output brb_pkg::cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DATA = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = ST_DATA;
			end
			ST_DATA: begin
				if (stat.out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// commands
	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && in_valid;
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.load    = (state_q == ST_DATA) && stat.out_free;

endmodule
`default_nettype wire

// ===== rtl/core/brb_dp.sv =====
// Datapath: capacity, head and fill registers, byte store and output register.
`timescale 1ns / 1ps
`default_nettype none
module brb_dp #(
	parameter int DEPTH = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [brb_pkg::CNT_W-1:0]   cfg_wdata,
	input  wire brb_pkg::cmd_t               cmd,
	output brb_pkg::stat_t                   stat,
	input  wire logic [brb_pkg::FUNC_W-1:0]  func,
	input  wire logic [brb_pkg::BYTE_W-1:0]  data_in,
	input  wire logic [brb_pkg::OFS_W-1:0]   offset,
	input  wire logic [brb_pkg::CNT_W-1:0]   count,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [brb_pkg::BYTE_W-1:0]  data_out,
	output logic                             done_res,
	output logic      [brb_pkg::CNT_W-1:0]   moved,
	output logic      [brb_pkg::CNT_W-1:0]   fill_level,
	output logic      [brb_pkg::CNT_W-1:0]   free_space
);

	localparam int CNT_W  = brb_pkg::CNT_W;
	localparam int SUM_W  = brb_pkg::SUM_W;
	// largest usable capacity: the register is 11 bits wide
	localparam int MAXCAP = (DEPTH < 2047) ? DEPTH : 2047;
	localparam int IW     = (MAXCAP > 2) ? $clog2(MAXCAP) : 1;
	localparam int AW     = $clog2(DEPTH);

	// register value 0 acts as 1, above DEPTH acts as DEPTH
	function automatic logic [CNT_W-1:0] cap_eff(input logic [CNT_W-1:0] w);
		logic [CNT_W-1:0] c;
		c = w;
		if (w == '0) begin
			c = CNT_W'(1);
		end else if (int'(w) > DEPTH) begin
			c = CNT_W'(DEPTH);
		end
		return c;
	endfunction

	logic [CNT_W-1:0]           cap_q;
	logic [IW-1:0]              head_q;
	logic [CNT_W-1:0]           fill_q;

	// captured operation word
	logic [brb_pkg::FUNC_W-1:0] func_q;
	logic [brb_pkg::BYTE_W-1:0] data_q;
	logic [brb_pkg::OFS_W-1:0]  offset_q;
	logic [CNT_W-1:0]           count_q;

	// operation outcome, held for the output load
	logic                       done_q;
	logic                       rd_q;
	logic [CNT_W-1:0]           moved_q;

	// output register
	logic                       out_valid_q;
	logic [brb_pkg::BYTE_W-1:0] data_out_q;
	logic                       done_out_q;
	logic [CNT_W-1:0]           moved_out_q;
	logic [CNT_W-1:0]           fill_out_q;
	logic [CNT_W-1:0]           free_out_q;

	logic [CNT_W-1:0]           flush_n;
	logic                       peek_ok;
	logic                       is_full;
	logic                       is_empty;
	logic [CNT_W-1:0]           addend;
	logic [SUM_W-1:0]           sum;
	logic [SUM_W-1:0]           wrapped;
	logic [IW-1:0]              pos;
	logic                       ram_we;
	logic                       ram_re;
	logic [IW-1:0]              ram_raddr;
	logic [brb_pkg::BYTE_W-1:0] ram_rdata;

	// capture the operation word on accept
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= func;
			data_q   <= data_in;
			offset_q <= offset;
			count_q  <= count;
		end
	end

	// operand conditions
	assign flush_n  = (count_q < fill_q) ? count_q : fill_q;
	assign peek_ok  = ({1'b0, offset_q} < fill_q);
	assign is_full  = (fill_q == cap_q);
	assign is_empty = (fill_q == '0);

	// index adder: head plus the op's distance, wrapped once at capacity
	always_comb begin
		case (func_q)
			brb_pkg::FUNC_WRITE: addend = fill_q;
			brb_pkg::FUNC_READ:  addend = CNT_W'(1);
			brb_pkg::FUNC_PEEK:  addend = {1'b0, offset_q};
			brb_pkg::FUNC_FLUSH: addend = flush_n;
			default:             addend = '0;
		endcase
	end

	assign sum     = SUM_W'(head_q) + SUM_W'(addend);
	assign wrapped = (sum >= SUM_W'(cap_q)) ? (sum - SUM_W'(cap_q)) : sum;
	assign pos     = wrapped[IW-1:0];

	// store access
	assign ram_we    = cmd.exec && (func_q == brb_pkg::FUNC_WRITE) && !is_full;
	assign ram_re    = cmd.exec && (((func_q == brb_pkg::FUNC_READ) && !is_empty) ||
		((func_q == brb_pkg::FUNC_PEEK) && peek_ok));
	assign ram_raddr = (func_q == brb_pkg::FUNC_READ) ? head_q : pos;

	brb_ram #(
		.WIDTH (brb_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(pos)),
		.wdata (data_q),
		.re    (ram_re),
		.raddr (AW'(ram_raddr)),
		.rdata (ram_rdata)
	);

	// capacity, head and fill; a capacity write empties the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= cap_eff(brb_pkg::CAP_RESET);
			head_q <= '0;
			fill_q <= '0;
		end else if (cfg_we) begin
			cap_q  <= cap_eff(cfg_wdata);
			head_q <= '0;
			fill_q <= '0;
		end else if (cmd.exec) begin
			case (func_q)
				brb_pkg::FUNC_WRITE: begin
					if (!is_full) fill_q <= fill_q + CNT_W'(1);
				end
				brb_pkg::FUNC_READ: begin
					if (!is_empty) begin
						head_q <= pos;
						fill_q <= fill_q - CNT_W'(1);
					end
				end
				brb_pkg::FUNC_FLUSH: begin
					head_q <= pos;
					fill_q <= fill_q - flush_n;
				end
				brb_pkg::FUNC_CLEAR: begin
					head_q <= '0;
					fill_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// outcome of the executed operation
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_q <= ram_re;
			case (func_q)
				brb_pkg::FUNC_WRITE: begin
					done_q  <= !is_full;
					moved_q <= CNT_W'(!is_full);
				end
				brb_pkg::FUNC_READ: begin
					done_q  <= !is_empty;
					moved_q <= CNT_W'(!is_empty);
				end
				brb_pkg::FUNC_PEEK: begin
					done_q  <= peek_ok;
					moved_q <= '0;
				end
				brb_pkg::FUNC_FLUSH: begin
					done_q  <= 1'b1;
					moved_q <= flush_n;
				end
				brb_pkg::FUNC_CLEAR: begin
					done_q  <= 1'b1;
					moved_q <= '0;
				end
				default: begin
					done_q  <= 1'b0;
					moved_q <= '0;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			data_out_q  <= rd_q ? ram_rdata : '0;
			done_out_q  <= done_q;
			moved_out_q <= moved_q;
			fill_out_q  <= fill_q;
			free_out_q  <= cap_q - fill_q;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign data_out   = data_out_q;
	assign done_res   = done_out_q;
	assign moved      = moved_out_q;
	assign fill_level = fill_out_q;
	assign free_space = free_out_q;

endmodule
`default_nettype wire

// ===== rtl/core/byte_ring_buffer.sv =====
// Top level of the byte ring buffer: controller, datapath and channel wiring.
`timescale 1ns / 1ps
`default_nettype none
// Byte FIFO over a ring of DEPTH byte slots, of which cfg_wdata selects how many are
// used before the indices wrap (0 acts as 1, above DEPTH acts as DEPTH); writing the
// capacity also empties the ring. Each input word is one operation (write, read,
// peek, flush, clear) and yields exactly one result word. One operation is in flight
// at a time: it passes the accept, execute and registered store read steps, and the
// next word is accepted as soon as the result sits in the output register. The byte
// store comes out of reset uninitialized and needs no clearing pass; only written
// entries are ever read.
module byte_ring_buffer #(
	parameter int DEPTH = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [brb_pkg::CNT_W-1:0]  cfg_wdata,
	brb_in_if.sink                          in,
	brb_out_if.source                       out
);

	brb_pkg::cmd_t  cmd;
	brb_pkg::stat_t stat;

	brb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	brb_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.stat       (stat),
		.func       (in.func),
		.data_in    (in.data_in),
		.offset     (in.offset),
		.count      (in.count),
		.out_valid  (out.valid),
		.out_ready  (out.ready),
		.data_out   (out.data_out),
		.done_res   (out.done_res),
		.moved      (out.moved),
		.fill_level (out.fill_level),
		.free_space (out.free_space)
	);

endmodule
`default_nettype wire

// ===== rtl/core/brb_chk.sv =====
// Port-level checker for the byte ring buffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_ring_buffer_defines.svh"
module brb_chk (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [brb_pkg::BYTE_W-1:0] data_out,
	input wire logic                       done_res,
	input wire logic [brb_pkg::CNT_W-1:0]  moved,
	input wire logic [brb_pkg::CNT_W-1:0]  fill_level,
	input wire logic [brb_pkg::CNT_W-1:0]  free_space
);

	logic [brb_pkg::SUM_W-1:0] cap_seen;

	assign cap_seen = {1'b0, fill_level} + {1'b0, free_space};

	// a stalled result word holds
	`BRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(fill_level) && $stable(moved))
	// one operation in flight: no accept right after an accept
	`BRB_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	// a failed operation moves nothing and returns no byte
	`BRB_ASSERT_NOW(a_fail_quiet, out_valid && !done_res, moved == '0 && data_out == '0)
	// never moves more than the capacity
	`BRB_ASSERT_NOW(a_moved_bound, out_valid, {1'b0, moved} <= cap_seen)

endmodule

bind byte_ring_buffer brb_chk u_brb_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in.valid),
	.in_ready   (in.ready),
	.out_valid  (out.valid),
	.out_ready  (out.ready),
	.data_out   (out.data_out),
	.done_res   (out.done_res),
	.moved      (out.moved),
	.fill_level (out.fill_level),
	.free_space (out.free_space)
);
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the byte ring buffer: random and directed operation words.
`timescale 1ns / 1ps
module tb_top;

	localparam int DEPTH         = 1024;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int LIMIT_NS      = 3_000_000;

	typedef struct packed {
		logic [brb_pkg::FUNC_W-1:0] func;
		logic [brb_pkg::BYTE_W-1:0] data_in;
		logic [brb_pkg::OFS_W-1:0]  offset;
		logic [brb_pkg::CNT_W-1:0]  count;
	} op_word_t;

	typedef struct packed {
		logic [brb_pkg::BYTE_W-1:0] data_out;
		logic                       done_res;
		logic [brb_pkg::CNT_W-1:0]  moved;
		logic [brb_pkg::CNT_W-1:0]  fill_level;
		logic [brb_pkg::CNT_W-1:0]  free_space;
	} res_word_t;

	// operation mixes for the random part
	typedef enum int {MIX_BAL, MIX_FILL, MIX_DRAIN, MIX_BULK} op_mix_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [brb_pkg::CNT_W-1:0] cfg_wdata;

	brb_in_if  op_ch ();
	brb_out_if res_ch ();

	byte_ring_buffer #(.DEPTH(DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in       (op_ch),
		.out      (res_ch)
	);

	// shadow copy of the ring
	logic [brb_pkg::BYTE_W-1:0] ring_mem [DEPTH];
	logic [brb_pkg::OFS_W-1:0]  ring_head;
	logic [brb_pkg::CNT_W-1:0]  ring_fill;
	logic [brb_pkg::CNT_W-1:0]  ring_cap_reg;

	op_word_t  pending_ops [$];
	res_word_t expected_results [$];

	int send_idle_pct;
	int recv_idle_pct;
	int holds_asked;
	int holds_served;
	int hold_left;
	int ops_accepted;
	int results_checked;
	int cap_settings;
	int fails;

	op_word_t  drv_word;
	op_word_t  acc_word;
	res_word_t want_word;

	// one operation on the shadow ring; returns the result word it yields
	function automatic res_word_t ring_apply(input op_word_t op);
		logic [brb_pkg::CNT_W-1:0] cap;
		logic [brb_pkg::SUM_W-1:0] pos;
		logic [brb_pkg::CNT_W-1:0] n;
		res_word_t                 r;
		if (ring_cap_reg == '0)
			cap = brb_pkg::CNT_W'(1);
		else if (ring_cap_reg > DEPTH)
			cap = brb_pkg::CNT_W'(DEPTH);
		else
			cap = ring_cap_reg;
		r = '0;
		if (ring_fill > cap)
			ring_fill = cap;
		if (ring_head >= cap)
			ring_head = '0;
		case (op.func)
			brb_pkg::FUNC_WRITE: begin
				if (ring_fill < cap) begin
					pos = brb_pkg::SUM_W'(ring_head) + brb_pkg::SUM_W'(ring_fill);
					if (pos >= cap)
						pos = pos - cap;
					ring_mem[pos[brb_pkg::OFS_W-1:0]] = op.data_in;
					ring_fill = ring_fill + 1'b1;
					r.done_res = 1'b1;
					r.moved = brb_pkg::CNT_W'(1);
				end
			end
			brb_pkg::FUNC_READ: begin
				if (ring_fill != '0) begin
					r.data_out = ring_mem[ring_head];
					pos = brb_pkg::SUM_W'(ring_head) + 1'b1;
					if (pos >= cap)
						pos = pos - cap;
					ring_head = pos[brb_pkg::OFS_W-1:0];
					ring_fill = ring_fill - 1'b1;
					r.done_res = 1'b1;
					r.moved = brb_pkg::CNT_W'(1);
				end
			end
			brb_pkg::FUNC_PEEK: begin
				if (brb_pkg::CNT_W'(op.offset) < ring_fill) begin
					pos = brb_pkg::SUM_W'(ring_head) + brb_pkg::SUM_W'(op.offset);
					if (pos >= cap)
						pos = pos - cap;
					r.data_out = ring_mem[pos[brb_pkg::OFS_W-1:0]];
					r.done_res = 1'b1;
				end
			end
			brb_pkg::FUNC_FLUSH: begin
				n = (op.count < ring_fill) ? op.count : ring_fill;
				ring_fill = ring_fill - n;
				pos = brb_pkg::SUM_W'(ring_head) + brb_pkg::SUM_W'(n);
				if (pos >= cap)
					pos = pos - cap;
				ring_head = pos[brb_pkg::OFS_W-1:0];
				r.done_res = 1'b1;
				r.moved = n;
			end
			brb_pkg::FUNC_CLEAR: begin
				ring_fill = '0;
				ring_head = '0;
				r.done_res = 1'b1;
			end
			default: ;
		endcase
		r.fill_level = ring_fill;
		r.free_space = cap - ring_fill;
		return r;
	endfunction

	// random operation word; fields that the operation ignores still toggle
	function automatic op_word_t random_op(input op_mix_t mix);
		op_word_t w;
		int       pw, pr, pp, pf, pc, roll;
		case (mix)
			MIX_FILL:  begin pw = 60; pr = 12; pp = 14; pf = 8;  pc = 2; end
			MIX_DRAIN: begin pw = 15; pr = 45; pp = 18; pf = 16; pc = 2; end
			MIX_BULK:  begin pw = 94; pr = 1;  pp = 4;  pf = 1;  pc = 0; end
			default:   begin pw = 35; pr = 30; pp = 18; pf = 10; pc = 3; end
		endcase
		w.data_in = brb_pkg::BYTE_W'($urandom_range(0, 255));
		roll = $urandom_range(0, 9);
		if (roll < 5)
			w.offset = brb_pkg::OFS_W'($urandom_range(0, 7));
		else if (roll < 8)
			w.offset = brb_pkg::OFS_W'($urandom_range(0, 63));
		else
			w.offset = brb_pkg::OFS_W'($urandom_range(0, 1023));
		roll = $urandom_range(0, 9);
		if (roll < 3 || mix == MIX_BULK)
			w.count = brb_pkg::CNT_W'($urandom_range(0, 3));
		else if (roll < 6)
			w.count = brb_pkg::CNT_W'($urandom_range(0, 31));
		else if (roll < 8)
			w.count = brb_pkg::CNT_W'($urandom_range(0, 2047));
		else if (roll < 9)
			w.count = brb_pkg::CNT_W'($urandom_range(1024, 2047));
		else
			w.count = '0;
		roll = $urandom_range(0, 99);
		if (roll < pw)
			w.func = brb_pkg::FUNC_WRITE;
		else if (roll < pw + pr)
			w.func = brb_pkg::FUNC_READ;
		else if (roll < pw + pr + pp)
			w.func = brb_pkg::FUNC_PEEK;
		else if (roll < pw + pr + pp + pf)
			w.func = brb_pkg::FUNC_FLUSH;
		else if (roll < pw + pr + pp + pf + pc)
			w.func = brb_pkg::FUNC_CLEAR;
		else
			w.func = brb_pkg::FUNC_CLEAR + brb_pkg::FUNC_W'($urandom_range(1, 3));
		return w;
	endfunction

	task automatic push_op(input logic [brb_pkg::FUNC_W-1:0] f, input int d, input int ofs,
		input int cnt);
		op_word_t w;
		w.func = f;
		w.data_in = brb_pkg::BYTE_W'(d);
		w.offset = brb_pkg::OFS_W'(ofs);
		w.count = brb_pkg::CNT_W'(cnt);
		pending_ops.push_back(w);
	endtask

	// sender side drained and every result back
	task automatic wait_drain();
		while (pending_ops.size() != 0 || op_ch.valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_idle(input int s, input int r);
		@(negedge clk);
		send_idle_pct = s;
		recv_idle_pct = r;
	endtask

	// capacity write, only with the ring idle; also empties the shadow ring
	task automatic write_capacity(input logic [brb_pkg::CNT_W-1:0] v);
		wait_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		ring_cap_reg = v;
		ring_head = '0;
		ring_fill = '0;
		cap_settings++;
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// one capacity setting with random words in chunks of one mix
	task automatic run_phase(input logic [brb_pkg::CNT_W-1:0] cap_val, input int n,
		input bit pause_mid, input bit hold_mid);
		op_mix_t mix;
		write_capacity(cap_val);
		mix = MIX_BAL;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) begin
				if (pause_mid)
					wait_drain();
				if (hold_mid) begin
					while (pending_ops.size() > 4)
						@(negedge clk);
					holds_asked++;
				end
			end
			if (i % 20 == 0)
				mix = op_mix_t'($urandom_range(0, 2));
			pending_ops.push_back(random_op(mix));
		end
	endtask

	task automatic check_field(input string name, input logic [brb_pkg::CNT_W-1:0] want,
		input logic [brb_pkg::CNT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fails++;
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// driver: next word from the queue, prediction on each accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_ch.valid <= 1'b0;
		end else begin
			if (op_ch.valid && op_ch.ready) begin
				acc_word.func = op_ch.func;
				acc_word.data_in = op_ch.data_in;
				acc_word.offset = op_ch.offset;
				acc_word.count = op_ch.count;
				expected_results.push_back(ring_apply(acc_word));
				ops_accepted++;
			end
			if (!op_ch.valid || op_ch.ready) begin
				if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					drv_word = pending_ops.pop_front();
					op_ch.valid <= 1'b1;
					op_ch.func <= drv_word.func;
					op_ch.data_in <= drv_word.data_in;
					op_ch.offset <= drv_word.offset;
					op_ch.count <= drv_word.count;
				end else begin
					op_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with long hold-offs on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left <= 0;
			holds_served <= 0;
		end else if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left <= HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// monitor: each result word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result word with none expected, actual data_out %0d fill %0d",
					$time, res_ch.data_out, res_ch.fill_level);
				fails++;
			end else begin
				want_word = expected_results.pop_front();
				check_field("data_out", brb_pkg::CNT_W'(want_word.data_out),
					brb_pkg::CNT_W'(res_ch.data_out));
				check_field("done_res", brb_pkg::CNT_W'(want_word.done_res),
					brb_pkg::CNT_W'(res_ch.done_res));
				check_field("moved", want_word.moved, res_ch.moved);
				check_field("fill_level", want_word.fill_level, res_ch.fill_level);
				check_field("free_space", want_word.free_space, res_ch.free_space);
				results_checked++;
			end
		end
	end

	// stimulus sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		op_ch.valid = 1'b0;
		op_ch.func = '0;
		op_ch.data_in = '0;
		op_ch.offset = '0;
		op_ch.count = '0;
		res_ch.ready = 1'b0;
		ring_head = '0;
		ring_fill = '0;
		ring_cap_reg = brb_pkg::CAP_RESET;
		send_idle_pct = 26;
		recv_idle_pct = 50;
		holds_asked = 0;
		ops_accepted = 0;
		results_checked = 0;
		cap_settings = 0;
		fails = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty ring, edges of the fields, every operation
		push_op(brb_pkg::FUNC_READ, 8'hff, 0, 0);
		push_op(brb_pkg::FUNC_PEEK, 0, 0, 0);
		push_op(brb_pkg::FUNC_FLUSH, 0, 0, 2047);
		push_op(brb_pkg::FUNC_WRITE, 8'h00, 0, 0);
		push_op(brb_pkg::FUNC_WRITE, 8'hff, 1023, 2047);
		push_op(brb_pkg::FUNC_WRITE, 8'ha5, 0, 0);
		push_op(brb_pkg::FUNC_PEEK, 0, 0, 0);
		push_op(brb_pkg::FUNC_PEEK, 0, 2, 0);
		push_op(brb_pkg::FUNC_PEEK, 0, 3, 0);
		push_op(brb_pkg::FUNC_PEEK, 0, 1023, 0);
		push_op(brb_pkg::FUNC_READ, 0, 0, 0);
		push_op(brb_pkg::FUNC_FLUSH, 0, 0, 1);
		push_op(brb_pkg::FUNC_READ, 0, 0, 0);
		push_op(brb_pkg::FUNC_READ, 0, 0, 0);
		// unused codes with all-ones noise
		push_op(brb_pkg::FUNC_CLEAR + 3'd1, 8'hff, 1023, 2047);
		push_op(brb_pkg::FUNC_CLEAR + 3'd2, 8'hff, 1023, 2047);
		push_op(brb_pkg::FUNC_CLEAR + 3'd3, 8'hff, 1023, 2047);
		push_op(brb_pkg::FUNC_WRITE, 8'h5a, 0, 0);
		push_op(brb_pkg::FUNC_CLEAR, 0, 0, 0);
		push_op(brb_pkg::FUNC_PEEK, 0, 0, 0);
		push_op(brb_pkg::FUNC_WRITE, 8'h3c, 0, 0);
		push_op(brb_pkg::FUNC_FLUSH, 0, 0, 0);
		push_op(brb_pkg::FUNC_READ, 0, 0, 0);

		// single-slot ring: full after one byte
		write_capacity(brb_pkg::CNT_W'(1));
		push_op(brb_pkg::FUNC_WRITE, 8'h11, 0, 0);
		push_op(brb_pkg::FUNC_WRITE, 8'h22, 0, 0);
		push_op(brb_pkg::FUNC_PEEK, 0, 0, 0);
		push_op(brb_pkg::FUNC_READ, 0, 0, 0);
		push_op(brb_pkg::FUNC_READ, 0, 0, 0);

		// receiver idles more than sender
		run_phase(brb_pkg::CNT_W'(0), 20, 1'b0, 1'b0);
		run_phase(brb_pkg::CNT_W'(3), 30, 1'b1, 1'b0);
		run_phase(brb_pkg::CNT_W'(17), 40, 1'b0, 1'b1);

		// sender idles more than receiver
		set_idle(50, 26);
		run_phase(brb_pkg::CNT_W'(2), 20, 1'b0, 1'b0);
		// full-depth ring: fill past the top, then drain
		write_capacity(brb_pkg::CNT_W'(2047));
		for (int i = 0; i < 1030; i++)
			push_op(brb_pkg::FUNC_WRITE, int'($urandom_range(0, 255)), 0, 0);
		for (int i = 0; i < 40; i++)
			pending_ops.push_back(random_op(MIX_DRAIN));
		run_phase(brb_pkg::CNT_W'(1024), 20, 1'b0, 1'b1);

		// no idling on either side
		set_idle(0, 0);
		run_phase(brb_pkg::CNT_W'(5), 20, 1'b0, 1'b0);
		run_phase(brb_pkg::CNT_W'(300), 20, 1'b1, 1'b0);
		run_phase(brb_pkg::CNT_W'(1025), 10, 1'b0, 1'b0);

		wait_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_results.size() != 0)
			fails++;
		$display("Ran %0d operation words over %0d capacity settings, %0d result words checked",
			ops_accepted, cap_settings, results_checked);
		$display("Covered empty and full rings, peeks past the fill, flush clamping and wrap");
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit
	initial begin
		#(LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
